@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ rtl/core/pfq_pkg.sv @@
// Package with the types and constants of the per-flow priority queue.
package pfq_pkg;
  localparam int MaxFlows = 8;
  localparam int Groups = MaxFlows + 1;
  localparam int HighDepth = 32;
  localparam int MiddleDepth = 32;
  localparam int LowDepth = 16;
  localparam int GW = $clog2(Groups);
  localparam int SW = $clog2(MaxFlows);
  localparam int HW = $clog2(HighDepth);
  localparam int MW = $clog2(MiddleDepth);
  localparam int LW = $clog2(LowDepth);

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_NOSLOT = 2'd2, ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic {OP_ENQ = 1'b0, OP_DEQ = 1'b1} op_t;

  typedef enum logic [1:0] {PR_HIGH = 2'd0, PR_MID = 2'd1, PR_LOW = 2'd2} prio_t;

  localparam logic CFG_HIGH = 1'b0;
  localparam logic CFG_MID = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [30:0] flow_id;
    logic [7:0]  priority_flag;
    logic [31:0] msg_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_handle;
    logic [30:0] out_flow;
  } out_item_t;

  // Classified request handed from the front part to the back part.
  typedef struct packed {
    op_t         op;
    logic [30:0] flow_id;
    prio_t       prio;
    logic [31:0] handle;
  } req_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_LOOK, BK_READ, BK_WAIT, BK_DONE
  } bk_state_t;
endpackage

@@ rtl/core/pfq_front.sv @@
// Front part: takes input beats, maps the flag and queues requests.
module pfq_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pfq_pkg::in_item_t in_data,
  input  logic [7:0]       high_code,
  input  logic [7:0]       mid_code,
  output logic             req_valid,
  output pfq_pkg::req_t    req,
  input  logic             req_take
);
  import pfq_pkg::*;

  req_t       q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  req_t       cls;
  logic       push;

  // Map the flag to a priority; high wins when codes are equal.
  always_comb begin
    cls.op = op_t'(in_data.operation);
    cls.flow_id = in_data.flow_id;
    cls.handle = in_data.msg_handle;
    if (in_data.priority_flag == high_code) cls.prio = PR_HIGH;
    else if (in_data.priority_flag == mid_code) cls.prio = PR_MID;
    else cls.prio = PR_LOW;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign req_valid = (cnt_r != 2'd0);
  assign req = q_r[rd_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, req_take};

  // Two-entry request queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= !wr_r;
      if (req_take) rd_r <= !rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= cls;
  end
endmodule

@@ rtl/core/pfq_back.sv @@
// Back part: flow table, round-robin order and the priority FIFO stores.
module pfq_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  pfq_pkg::req_t     req,
  output logic              req_take,
  output logic              out_valid,
  input  logic              out_stall,
  output pfq_pkg::out_item_t out_data
);
  import pfq_pkg::*;

  // Memories of message handles, one row per group.
  logic [31:0] hmem [Groups*HighDepth];
  logic [31:0] mmem [Groups*MiddleDepth];
  logic [31:0] lmem [Groups*LowDepth];
  logic [31:0] rd_h_r, rd_m_r, rd_l_r;

  logic [30:0]   owner_r [Groups];
  logic [Groups-1:0] active_r, active_nxt;
  logic [GW-1:0] order_r [MaxFlows];
  logic [SW-1:0] ohead_r, ohead_nxt;
  logic [SW:0]   ocnt_r, ocnt_nxt;
  logic [HW-1:0] hh_r [Groups];
  logic [HW:0]   hc_r [Groups];
  logic [MW-1:0] mh_r [Groups];
  logic [MW:0]   mc_r [Groups];
  logic [LW-1:0] lh_r [Groups];
  logic [LW:0]   lc_r [Groups];

  bk_state_t st_r, st_nxt;
  req_t      cur_r;
  logic [GW-1:0] g_r, g_nxt;
  logic      hit_r, hit_nxt;
  out_item_t res_r, res_nxt;
  out_item_t out_r, out_nxt;
  logic      ov_r, ov_nxt;

  logic [GW-1:0] found, freeslot;
  logic          fnd, fre;
  logic [GW-1:0] sel_g;
  logic [GW-1:0] tgt;
  logic          deq_any;
  prio_t         deq_p;
  logic          deq_ok, alloc, deq_go, out_go, enq_go;
  status_t       enq_status;

  // Flow lookup and lowest free slot over the small table.
  always_comb begin
    found = '0;
    freeslot = '0;
    fnd = 1'b0;
    fre = 1'b0;
    for (int i = Groups - 1; i >= 1; i--) begin
      if (active_r[i] && owner_r[i] == cur_r.flow_id) begin
        fnd = 1'b1;
        found = GW'(i);
      end
      if (!active_r[i]) begin
        fre = 1'b1;
        freeslot = GW'(i);
      end
    end
  end

  // Group whose head entries are read from memory.
  assign sel_g = g_r;

  always_ff @(posedge clk) begin
    rd_h_r <= hmem[{sel_g, hh_r[sel_g]}];
    rd_m_r <= mmem[{sel_g, mh_r[sel_g]}];
    rd_l_r <= lmem[{sel_g, lh_r[sel_g]}];
  end

  always_comb begin
    tgt = fnd ? found : freeslot;
    if (cur_r.flow_id == 31'd0) tgt = '0;
  end

  // Per-group FIFO pick for a dequeue.
  always_comb begin
    deq_any = 1'b1;
    deq_p = PR_HIGH;
    if (hc_r[g_r] != '0) deq_p = PR_HIGH;
    else if (mc_r[g_r] != '0) deq_p = PR_MID;
    else if (lc_r[g_r] != '0) deq_p = PR_LOW;
    else deq_any = 1'b0;
  end

  assign alloc = (st_r == BK_LOOK) && (cur_r.op == OP_ENQ) && (cur_r.flow_id != 31'd0)
                 && !fnd && fre;
  assign deq_ok = (hit_r || (g_r != '0 && active_r[g_r])) && deq_any;
  assign deq_go = (st_r == BK_WAIT) && (cur_r.op == OP_DEQ);
  assign out_go = (st_r == BK_DONE) && (!ov_r || !out_stall);
  assign enq_go = out_go && (cur_r.op == OP_ENQ) && hit_r;

  // Enqueue status from the slot lookup and the target FIFO fill.
  always_comb begin
    enq_status = ST_OK;
    if (!hit_r) enq_status = ST_NOSLOT;
    else begin
      case (cur_r.prio)
        PR_HIGH: if (hc_r[g_r] == (HW+1)'(HighDepth)) enq_status = ST_FULL;
        PR_MID:  if (mc_r[g_r] == (MW+1)'(MiddleDepth)) enq_status = ST_FULL;
        default: if (lc_r[g_r] == (LW+1)'(LowDepth)) enq_status = ST_FULL;
      endcase
    end
  end

  // Sequencer: look up, read FIFO heads on a dequeue, then hand the result to the output register.
  always_comb begin
    st_nxt = st_r;
    g_nxt = g_r;
    hit_nxt = hit_r;
    res_nxt = res_r;
    out_nxt = out_r;
    ov_nxt = ov_r;
    req_take = 1'b0;
    active_nxt = active_r;
    ohead_nxt = ohead_r;
    ocnt_nxt = ocnt_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        if (req_valid) begin
          req_take = 1'b1;
          st_nxt = BK_LOOK;
        end
      end
      BK_LOOK: begin
        res_nxt = '0;
        hit_nxt = 1'b0;
        if (cur_r.op == OP_ENQ) begin
          g_nxt = tgt;
          hit_nxt = (cur_r.flow_id == 31'd0) || fnd || fre;
          st_nxt = BK_DONE;
        end else if (hc_r[0] != '0 || mc_r[0] != '0 || lc_r[0] != '0) begin
          g_nxt = '0;
          hit_nxt = 1'b1;
          st_nxt = BK_READ;
        end else if (ocnt_r == '0) begin
          res_nxt.status = ST_EMPTY;
          st_nxt = BK_DONE;
        end else begin
          g_nxt = order_r[ohead_r];
          ohead_nxt = ohead_r + 1'b1;
          ocnt_nxt = ocnt_r - 1'b1;
          st_nxt = BK_READ;
        end
      end
      BK_READ: st_nxt = BK_WAIT;
      BK_WAIT: begin
        st_nxt = BK_DONE;
        if (cur_r.op == OP_DEQ) begin
          if (deq_ok) begin
            res_nxt.status = ST_OK;
            res_nxt.out_flow = hit_r ? 31'd0 : owner_r[g_r];
            case (deq_p)
              PR_HIGH: res_nxt.out_handle = rd_h_r;
              PR_MID:  res_nxt.out_handle = rd_m_r;
              default: res_nxt.out_handle = rd_l_r;
            endcase
          end else begin
            res_nxt = '0;
            res_nxt.status = ST_EMPTY;
          end
        end
      end
      BK_DONE: begin
        if (out_go) begin
          ov_nxt = 1'b1;
          st_nxt = BK_IDLE;
          if (cur_r.op == OP_ENQ) begin
            out_nxt = '0;
            out_nxt.status = enq_status;
          end else begin
            out_nxt = res_r;
          end
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
    // A new flow joins the tail of the order.
    if (alloc) begin
      active_nxt[freeslot] = 1'b1;
      ocnt_nxt = ocnt_r + 1'b1;
    end
    // A served flow goes back to the tail; an empty head flow is released.
    if (deq_go && !hit_r) begin
      if (deq_ok) ocnt_nxt = ocnt_r + 1'b1;
      else if (g_r != '0) active_nxt[g_r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ov_r <= 1'b0;
      active_r <= Groups'(1);
      ohead_r <= '0;
      ocnt_r <= '0;
      for (int i = 0; i < Groups; i++) begin
        hh_r[i] <= '0; hc_r[i] <= '0;
        mh_r[i] <= '0; mc_r[i] <= '0;
        lh_r[i] <= '0; lc_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      ohead_r <= ohead_nxt;
      ocnt_r <= ocnt_nxt;
      active_r <= active_nxt;
      if (alloc) begin
        hh_r[freeslot] <= '0; hc_r[freeslot] <= '0;
        mh_r[freeslot] <= '0; mc_r[freeslot] <= '0;
        lh_r[freeslot] <= '0; lc_r[freeslot] <= '0;
        order_r[SW'(ohead_r + ocnt_r[SW-1:0])] <= freeslot;
      end
      // Enqueue write into the selected FIFO.
      if (enq_go) begin
        unique case (cur_r.prio)
          PR_HIGH: if (hc_r[g_r] != (HW+1)'(HighDepth)) hc_r[g_r] <= hc_r[g_r] + 1'b1;
          PR_MID:  if (mc_r[g_r] != (MW+1)'(MiddleDepth)) mc_r[g_r] <= mc_r[g_r] + 1'b1;
          default: if (lc_r[g_r] != (LW+1)'(LowDepth)) lc_r[g_r] <= lc_r[g_r] + 1'b1;
        endcase
      end
      // Dequeue pop after the heads have been read.
      if (deq_go && deq_ok) begin
        unique case (deq_p)
          PR_HIGH: begin hh_r[g_r] <= hh_r[g_r] + 1'b1; hc_r[g_r] <= hc_r[g_r] - 1'b1; end
          PR_MID:  begin mh_r[g_r] <= mh_r[g_r] + 1'b1; mc_r[g_r] <= mc_r[g_r] - 1'b1; end
          default: begin lh_r[g_r] <= lh_r[g_r] + 1'b1; lc_r[g_r] <= lc_r[g_r] - 1'b1; end
        endcase
        if (!hit_r) order_r[SW'(ohead_r + ocnt_r[SW-1:0])] <= g_r;
      end
    end
  end

  // Working request, result and output registers.
  always_ff @(posedge clk) begin
    if (st_r == BK_IDLE && req_valid) cur_r <= req;
    g_r <= g_nxt;
    hit_r <= hit_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
    if (alloc) owner_r[freeslot] <= cur_r.flow_id;
  end

  // Memory writes for an accepted enqueue.
  always_ff @(posedge clk) begin
    if (enq_go) begin
      unique case (cur_r.prio)
        PR_HIGH: if (hc_r[g_r] != (HW+1)'(HighDepth))
          hmem[{g_r, HW'(hh_r[g_r] + hc_r[g_r][HW-1:0])}] <= cur_r.handle;
        PR_MID: if (mc_r[g_r] != (MW+1)'(MiddleDepth))
          mmem[{g_r, MW'(mh_r[g_r] + mc_r[g_r][MW-1:0])}] <= cur_r.handle;
        default: if (lc_r[g_r] != (LW+1)'(LowDepth))
          lmem[{g_r, LW'(lh_r[g_r] + lc_r[g_r][LW-1:0])}] <= cur_r.handle;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_data = out_r;
endmodule

@@ rtl/core/per_flow_priority_round_robin_queue.sv @@
// Top level of the per-flow priority round-robin message queue.
// Usage:
// - in_* carries one request beat: enqueue a handle for a flow, or dequeue.
// - out_* returns exactly one result beat per request: status, handle, flow.
// - cfg_* writes the two flag codes; register 0 selects high, 1 middle.
// - A beat moves when valid is high and stall is low; cfg when valid and ready.
// Timing:
// - From the accepting edge to a valid result, an enqueue passes the back-end
//   steps take, lookup and result handoff; a dequeue adds head read and wait
//   between lookup and handoff.
// - One request is in work at a time: the back end takes the next request
//   only after the last result has been handed to the output register.
// - A two-entry request queue lets the input side accept while a result waits.
// - When out_stall holds, the output register keeps its beat and the back end
//   works the next request up to its last step; the front queue fills and
//   then raises in_stall.
// Reset:
// - rst_n clears flows, order and FIFO counters; the codes return to 0 and 1.
// - No clearing pass is needed; unwritten memory entries are never read.
module per_flow_priority_round_robin_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pfq_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data
);
  import pfq_pkg::*;
  `include "assert_macros.svh"

  logic [7:0] high_code_r, mid_code_r;
  logic       req_valid, req_take;
  req_t       req;

  assign cfg_ready = 1'b1;

  // Flag code registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_code_r <= 8'd0;
      mid_code_r <= 8'd1;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_HIGH) high_code_r <= cfg_data;
      else mid_code_r <= cfg_data;
    end
  end

  pfq_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .high_code(high_code_r), .mid_code(mid_code_r),
    .req_valid, .req, .req_take
  );

  pfq_back u_back (
    .clk, .rst_n, .req_valid, .req, .req_take,
    .out_valid, .out_stall, .out_data
  );

  // Checks on the internal handoff.
  `ASSERT_CLK(a_take_valid, clk, rst_n, req_take |-> req_valid, "take without request")
  `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid,
              "result dropped under stall")
  `ASSERT_CLK(a_enq_noflow, clk, rst_n,
              (out_valid && out_data.status == ST_NOSLOT) |-> out_data.out_flow == 31'd0,
              "slot error carries a flow")
endmodule

@@ sim/per_flow_priority_round_robin_queue_test.sv @@
// Testbench for the per-flow priority round-robin queue, with a scoreboard that predicts each result.
`timescale 1ns / 100ps

// Mirrors the flows, the service order and the priority FIFOs, and keeps the expected results.
class queue_scoreboard;
  localparam int Flows = pfq_pkg::MaxFlows;
  localparam int Groups = pfq_pkg::Groups;

  bit [7:0] high_code;
  bit [7:0] mid_code;
  bit [30:0] owner[Groups];
  bit active[Groups];
  int unsigned order[Flows];
  int unsigned order_head;
  int unsigned order_count;
  bit [31:0] store[Groups][3][32];
  int unsigned fifo_head[Groups][3];
  int unsigned fifo_count[Groups][3];
  pfq_pkg::out_item_t expected_results[$];
  int errors;
  int checked;
  int full_seen;
  int noslot_seen;
  int empty_seen;

  function new();
    high_code = 8'd0;
    mid_code = 8'd1;
    order_head = 0;
    order_count = 0;
    errors = 0;
    checked = 0;
    foreach (active[g]) active[g] = 1'b0;
    foreach (fifo_count[g, p]) begin
      fifo_count[g][p] = 0;
      fifo_head[g][p] = 0;
    end
    active[0] = 1'b1;
  endfunction

  function void set_code(logic index, bit [7:0] value);
    if (index == pfq_pkg::CFG_HIGH) high_code = value;
    else mid_code = value;
  endfunction

  function int unsigned depth_of(pfq_pkg::prio_t p);
    return (p == pfq_pkg::PR_LOW) ? pfq_pkg::LowDepth : pfq_pkg::HighDepth;
  endfunction

  function pfq_pkg::status_t push(int unsigned g, pfq_pkg::prio_t p, bit [31:0] h);
    int unsigned d;
    d = depth_of(p);
    if (fifo_count[g][p] >= d) return pfq_pkg::ST_FULL;
    store[g][p][(fifo_head[g][p] + fifo_count[g][p]) % d] = h;
    fifo_count[g][p]++;
    return pfq_pkg::ST_OK;
  endfunction

  // Pops in strict priority; returns 0 when the group holds nothing.
  function bit pop(int unsigned g, output bit [31:0] h);
    pfq_pkg::prio_t p;
    h = '0;
    for (int i = 0; i < 3; i++) begin
      p = pfq_pkg::prio_t'(i);
      if (fifo_count[g][p] != 0) begin
        h = store[g][p][fifo_head[g][p]];
        fifo_head[g][p] = (fifo_head[g][p] + 1) % depth_of(p);
        fifo_count[g][p]--;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function void append(int unsigned g);
    if (order_count >= Flows) return;
    order[(order_head + order_count) % Flows] = g;
    order_count++;
  endfunction

  // Notes one accepted request beat and queues the result it must produce.
  function void note_request(pfq_pkg::in_item_t req);
    pfq_pkg::out_item_t res;
    pfq_pkg::prio_t p;
    int unsigned found;
    int unsigned g;
    bit [31:0] h;
    res = '0;
    res.status = pfq_pkg::ST_OK;
    if (req.operation == pfq_pkg::OP_ENQ) begin
      if (req.priority_flag == high_code) p = pfq_pkg::PR_HIGH;
      else if (req.priority_flag == mid_code) p = pfq_pkg::PR_MID;
      else p = pfq_pkg::PR_LOW;
      if (req.flow_id == 0) begin
        res.status = push(0, p, req.msg_handle);
      end else begin
        found = 0;
        for (int i = 1; i < Groups; i++)
          if (found == 0 && active[i] && owner[i] == req.flow_id) found = i;
        // A new flow takes the lowest free slot and joins the tail of the order.
        if (found == 0) begin
          for (int i = 1; i < Groups; i++)
            if (found == 0 && !active[i]) found = i;
          if (found != 0) begin
            active[found] = 1'b1;
            owner[found] = req.flow_id;
            for (int k = 0; k < 3; k++) begin
              fifo_head[found][k] = 0;
              fifo_count[found][k] = 0;
            end
            append(found);
          end
        end
        if (found == 0) res.status = pfq_pkg::ST_NOSLOT;
        else res.status = push(found, p, req.msg_handle);
      end
    end else begin
      if (pop(0, h)) begin
        res.out_handle = h;
      end else if (order_count == 0) begin
        res.status = pfq_pkg::ST_EMPTY;
      end else begin
        g = order[order_head];
        order_head = (order_head + 1) % Flows;
        order_count--;
        // An empty head flow is released and the dequeue reports nothing.
        if (g != 0 && active[g] && pop(g, h)) begin
          append(g);
          res.out_handle = h;
          res.out_flow = owner[g];
        end else begin
          if (g != 0) active[g] = 1'b0;
          res.status = pfq_pkg::ST_EMPTY;
        end
      end
    end
    case (res.status)
      pfq_pkg::ST_FULL: full_seen++;
      pfq_pkg::ST_NOSLOT: noslot_seen++;
      pfq_pkg::ST_EMPTY: empty_seen++;
      default: ;
    endcase
    expected_results.push_back(res);
  endfunction

  // Compares one result beat with the oldest expectation.
  function void check_result(pfq_pkg::out_item_t got);
    pfq_pkg::out_item_t exp;
    checked++;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result beat, actual %h", $time, got);
      return;
    end
    exp = expected_results.pop_front();
    if (got.status != exp.status) begin
      errors++;
      $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
    end
    if (got.out_handle != exp.out_handle) begin
      errors++;
      $display("%0t: handle expected %h actual %h", $time, exp.out_handle, got.out_handle);
    end
    if (got.out_flow != exp.out_flow) begin
      errors++;
      $display("%0t: flow expected %h actual %h", $time, exp.out_flow, got.out_flow);
    end
  endfunction
endclass

module per_flow_priority_round_robin_queue_test;
  import pfq_pkg::*;

  localparam int WatchLimit = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_HIGH;
  logic [7:0] cfg_data = '0;

  queue_scoreboard board = new();
  bit calm = 1'b0;
  bit timed_out = 1'b0;
  int idle_cycles = 0;
  int sent = 0;
  bit [30:0] flow_pool[12];

  per_flow_priority_round_robin_queue DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Record accepted beats, check results and watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_request(in_data);
      if (out_valid && !out_stall) board.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
          || (!in_valid && board.expected_results.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit && !timed_out) begin
        timed_out = 1'b1;
        $display("%0t: no progress for %0d cycles", $time, WatchLimit);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver stalls in random bursts until the calm final part.
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Sends one request beat; entered and left at a falling edge.
  task automatic send_request(logic op, bit [30:0] flow, bit [7:0] flag, bit [31:0] handle);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{operation: op, flow_id: flow, priority_flag: flag, msg_handle: handle};
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_code(logic index, bit [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    board.set_code(index, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drains the block before a register write or the end of the run.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.expected_results.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic random_phase(int count, int deq_weight, int pool_size);
    logic op;
    bit [30:0] flow;
    bit [7:0] flag;
    int pick;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 99) < deq_weight) ? OP_DEQ : OP_ENQ;
      pick = $urandom_range(0, 99);
      if (pick < 25) flow = '0;
      else if (pick < 92) flow = flow_pool[$urandom_range(0, pool_size - 1)];
      else flow = 31'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 4) flag = board.high_code;
      else if (pick < 7) flag = board.mid_code;
      else flag = 8'($urandom_range(0, 255));
      send_request(op, flow, flag, $urandom);
    end
  endtask

  initial begin
    bit [7:0] codes[5][2];
    codes = '{'{8'd0, 8'd1}, '{8'd255, 8'd0}, '{8'd7, 8'd7}, '{8'd128, 8'd255}, '{8'd3, 8'd200}};
    flow_pool[0] = 31'h7FFF_FFFF;
    flow_pool[1] = 31'd1;
    for (int i = 2; i < 12; i++) flow_pool[i] = 31'($urandom_range(2, 100000)) | 31'h4000_0000;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: each priority of the internal group, extreme fields, empty dequeues.
    send_request(OP_ENQ, 31'd0, 8'd1, 32'hFFFF_FFFF);
    send_request(OP_ENQ, 31'd0, 8'd255, 32'h0000_0000);
    send_request(OP_ENQ, 31'd0, 8'd0, 32'h1234_5678);
    repeat (4) send_request(OP_DEQ, 31'h7FFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    // Fill every flow slot, then one more flow finds no slot.
    for (int i = 0; i < 9; i++)
      send_request(OP_ENQ, (i == 0) ? 31'h7FFF_FFFF : 31'(i), 8'(i % 3), 32'(i * 3 + 1));
    // Rotate through the flows; the last dequeue finds the first flow empty and frees it.
    repeat (9) send_request(OP_DEQ, '0, '0, '0);
    drain();

    // Random phases under several code settings, the last one without idling.
    for (int ph = 0; ph < 5; ph++) begin
      write_code(CFG_HIGH, codes[ph][0]);
      write_code(CFG_MID, codes[ph][1]);
      if (ph == 4) calm = 1'b1;
      case (ph)
        0: random_phase(120, 45, 12);
        1: random_phase(120, 15, 3);
        2: random_phase(110, 30, 12);
        3: random_phase(120, 70, 12);
        default: random_phase(100, 45, 10);
      endcase
      drain();
    end

    $display("Sent %0d requests, checked %0d results across 5 flag code settings.",
             sent, board.checked);
    $display("Seen: %0d full FIFO, %0d no free slot, %0d empty dequeue results.",
             board.full_seen, board.noslot_seen, board.empty_seen);
    if (board.errors == 0 && board.expected_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
